### hdl/dsrp_pkg.sv
// ----------------------------------------------------------------------------
// dsrp_pkg
// Shared field widths, command codes and status codes for the dense set unit.
// ----------------------------------------------------------------------------
package dsrp_pkg;

   localparam int CMD_W    = 2;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 7;
   // bit counter for the 32-step restoring modulo
   localparam int BIT_CNT_W = 5;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [DATA_W-1:0]   data_type;

   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_REMOVE = 2'd1;
   localparam cmd_type CMD_PICK   = 2'd2;
   localparam cmd_type CMD_NOP    = 2'd3;

   localparam status_type ST_DONE  = 2'd0;
   localparam status_type ST_MATCH = 2'd1;
   localparam status_type ST_FULL  = 2'd2;
   localparam status_type ST_EMPTY = 2'd3;

endpackage

### hdl/dsrp_ram.sv
// ----------------------------------------------------------------------------
// dsrp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dsrp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/dense_set_with_random_pick_unit.sv
// Insert and remove scan the entries in order, one entry read and compared per cycle through
//   the RAM port; a remove that hits any entry but the last moves the last entry into the
//   freed slot. Random pick: 32 restoring modulo steps, then RAM read, capture and response;
//   pick on an empty set and the unused command respond directly. Throughput: one word at a time.
// Reset: synchronous, clears fill count and control; entries are not cleared.
// ----------------------------------------------------------------------------
// dense_set_with_random_pick_unit
// Densely packed set of signed 32-bit values with insert, remove and random
// pick, driven by a small sequencer around one entry RAM and one compare unit.
// ----------------------------------------------------------------------------
module dense_set_with_random_pick_unit
   import dsrp_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CMD_W-1:0]         req_cmd,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic [DATA_W-1:0]        req_random_draw,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic signed [DATA_W-1:0] rsp_picked_value,
   output logic [OCC_W-1:0]         rsp_occupancy
);

   // address width and count width (count must hold CAPACITY itself)
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_WAIT   = 3'd4;
   localparam logic [2:0] S_RESP   = 3'd5;

   // control state
   logic [2:0]           state_ff,   state_in;
   logic [CW-1:0]        cnt_ff,     cnt_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic                 rsp_vld_ff, rsp_vld_in;

   // working registers
   cmd_type              cmd_ff,     cmd_in;
   data_type             value_ff,   value_in;
   data_type             draw_ff,    draw_in;
   logic [CW-1:0]        scan_ff,    scan_in;
   logic [AW-1:0]        cmp_idx_ff, cmp_idx_in;
   logic [AW-1:0]        addr_ff,    addr_in;
   logic [AW-1:0]        pos_ff,     pos_in;
   logic [CW-1:0]        rem_ff,     rem_in;
   logic [BIT_CNT_W-1:0] bit_ff,     bit_in;
   status_type           status_ff,  status_in;
   data_type             picked_ff,  picked_in;

   // output word register
   status_type           rsp_status_ff, rsp_status_in;
   data_type             rsp_picked_ff, rsp_picked_in;
   logic [OCC_W-1:0]     rsp_occ_ff,    rsp_occ_in;

   // RAM port
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   data_type             wr_data;
   logic [AW-1:0]        rd_addr;
   data_type             rd_data;

   // shared compare / subtract unit and helpers
   logic                 match;
   logic [CW:0]          rem_shift;
   logic [CW:0]          rem_diff;
   logic [CW-1:0]        last_cnt;
   logic [CW+OCC_W-1:0]  occ_wide;

   assign match     = cmp_vld_ff && (rd_data == value_ff);
   assign rem_shift = {rem_ff, draw_ff[DATA_W-1]};
   assign rem_diff  = rem_shift - {1'b0, cnt_ff};
   assign last_cnt  = cnt_ff - CW'(1);
   assign occ_wide  = {{OCC_W{1'b0}}, cnt_ff};

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmp_vld_in    = 1'b0;
      rsp_vld_in    = rsp_vld_ff;
      cmd_in        = cmd_ff;
      value_in      = value_ff;
      draw_in       = draw_ff;
      scan_in       = scan_ff;
      cmp_idx_in    = cmp_idx_ff;
      addr_in       = addr_ff;
      pos_in        = pos_ff;
      rem_in        = rem_ff;
      bit_in        = bit_ff;
      status_in     = status_ff;
      picked_in     = picked_ff;
      rsp_status_in = rsp_status_ff;
      rsp_picked_in = rsp_picked_ff;
      rsp_occ_in    = rsp_occ_ff;
      wr_en         = 1'b0;
      wr_addr       = cnt_ff[AW-1:0];
      wr_data       = value_ff;
      rd_addr       = addr_ff;

      // drop the output word once taken
      if (rsp_vld_ff && rsp_ready) begin
         rsp_vld_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_cmd;
               value_in  = $unsigned(req_value);
               draw_in   = req_random_draw;
               scan_in   = '0;
               rem_in    = '0;
               bit_in    = '0;
               status_in = ST_DONE;
               picked_in = '0;
               unique case (req_cmd) inside
                  CMD_INSERT, CMD_REMOVE: state_in = S_SEARCH;
                  CMD_PICK: begin
                     if (cnt_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_RESP;
                     end else begin
                        state_in  = S_DIV;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end

         S_SEARCH: begin
            // one entry issued and one compared per cycle
            rd_addr = scan_ff[AW-1:0];
            if (match) begin
               pos_in = cmp_idx_ff;
               if (cmd_ff == CMD_INSERT) begin
                  status_in = ST_MATCH;
                  state_in  = S_RESP;
               end else if (cmp_idx_ff != last_cnt[AW-1:0]) begin
                  // move the last entry into the freed slot
                  addr_in  = last_cnt[AW-1:0];
                  state_in = S_READ;
               end else begin
                  cnt_in   = last_cnt;
                  state_in = S_RESP;
               end
            end else if (scan_ff < cnt_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff[AW-1:0];
               scan_in    = scan_ff + CW'(1);
            end else if (!cmp_vld_ff) begin
               // scan finished without a hit
               state_in = S_RESP;
               if (cmd_ff == CMD_REMOVE) begin
                  status_in = ST_MATCH;
               end else if (cnt_ff == CAP_CNT) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + CW'(1);
               end
            end
         end

         S_DIV: begin
            // restoring modulo, one draw bit per cycle, MSB first
            draw_in = {draw_ff[DATA_W-2:0], 1'b0};
            if (rem_shift >= {1'b0, cnt_ff}) begin
               rem_in = rem_diff[CW-1:0];
            end else begin
               rem_in = rem_shift[CW-1:0];
            end
            bit_in = bit_ff + BIT_CNT_W'(1);
            if (bit_ff == '1) begin
               state_in = S_READ;
            end
         end

         S_READ: begin
            if (cmd_ff == CMD_PICK) begin
               addr_in = rem_ff[AW-1:0];
               rd_addr = rem_ff[AW-1:0];
            end
            state_in = S_WAIT;
         end

         S_WAIT: begin
            if (cmd_ff == CMD_PICK) begin
               picked_in = rd_data;
            end else begin
               wr_en   = 1'b1;
               wr_addr = pos_ff;
               wr_data = rd_data;
               cnt_in  = last_cnt;
            end
            state_in = S_RESP;
         end

         S_RESP: begin
            // hold until the output register is free
            if (!rsp_vld_ff || rsp_ready) begin
               rsp_vld_in    = 1'b1;
               rsp_status_in = status_ff;
               rsp_picked_in = picked_ff;
               rsp_occ_in    = occ_wide[OCC_W-1:0];
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cnt_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      value_ff      <= value_in;
      draw_ff       <= draw_in;
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      addr_ff       <= addr_in;
      pos_ff        <= pos_in;
      rem_ff        <= rem_in;
      bit_ff        <= bit_in;
      status_ff     <= status_in;
      picked_ff     <= picked_in;
      rsp_status_ff <= rsp_status_in;
      rsp_picked_ff <= rsp_picked_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   dsrp_ram #(
      .WIDTH(DATA_W),
      .DEPTH(CAPACITY)
   ) u_entries (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_picked_value = $signed(rsp_picked_ff);
   assign rsp_occupancy    = rsp_occ_ff;

endmodule

### test/dense_set_with_random_pick_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_set_with_random_pick_unit_tb
// Self-checking bench for the dense set unit. Request words are driven in
// random bursts. A scoreboard keeps its own copy of the set and predicts each
// response word: status, picked value and occupancy.
// ----------------------------------------------------------------------------
module dense_set_with_random_pick_unit_tb
   import dsrp_pkg::*;
();

   localparam int          CAPACITY    = 64;
   localparam int          POOL_SIZE   = 80;
   localparam int          RANDOM_WORDS = 1550;
   localparam int unsigned CYCLE_LIMIT = 2000000;
   localparam int          DRAIN_CYCLES = 100;

   typedef logic [OCC_W-1:0] occ_type;

   // One predicted response word.
   typedef struct packed {
      status_type status;
      data_type   picked;
      occ_type    occupancy;
   } outcome_type;

   // -------------------------------------------------------------------------
   // Scoreboard: owns the predicted set contents and the queue of outcomes
   // still owed by the block.
   // -------------------------------------------------------------------------
   class set_scoreboard;
      data_type    held[CAPACITY];
      int unsigned held_count;
      outcome_type owed[$];
      int unsigned fail_count;

      function new();
         held_count = 0;
         fail_count = 0;
      endfunction

      function int find_slot(data_type v);
         for (int i = 0; i < held_count; i++)
            if (held[i] == v) return i;
         return -1;
      endfunction

      // Apply an accepted request word to the shadow set and queue its outcome.
      function void note_request(cmd_type cmd, data_type value, data_type draw);
         outcome_type o;
         int          slot;
         o.status = ST_DONE;
         o.picked = '0;
         slot = find_slot(value);
         case (cmd)
            CMD_INSERT: begin
               if (slot >= 0) o.status = ST_MATCH;
               else if (held_count >= CAPACITY) o.status = ST_FULL;
               else begin
                  held[held_count] = value;
                  held_count++;
               end
            end
            CMD_REMOVE: begin
               if (slot < 0) o.status = ST_MATCH;
               else begin
                  // backfill the hole with the last entry
                  held[slot] = held[held_count-1];
                  held_count--;
               end
            end
            CMD_PICK: begin
               if (held_count == 0) o.status = ST_EMPTY;
               else o.picked = held[draw % held_count];
            end
            default: ;
         endcase
         o.occupancy = held_count[OCC_W-1:0];
         owed = {owed, o};
      endfunction

      function void check_response(status_type st, data_type pv, occ_type occ);
         outcome_type want;
         if (owed.size() == 0) begin
            $error("response word with nothing owed: status %0d occupancy %0d", st, occ);
            fail_count++;
            return;
         end
         want = owed.pop_front();
         if (st !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, st);
            fail_count++;
         end
         if (pv !== want.picked) begin
            $error("picked_value: expected %0d, actual %0d",
                   $signed(want.picked), $signed(pv));
            fail_count++;
         end
         if (occ !== want.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", want.occupancy, occ);
            fail_count++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup
   // -------------------------------------------------------------------------
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [CMD_W-1:0]         req_cmd = CMD_NOP;
   logic signed [DATA_W-1:0] req_value = '0;
   logic [DATA_W-1:0]        req_random_draw = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [STATUS_W-1:0]      rsp_status;
   logic signed [DATA_W-1:0] rsp_picked_value;
   logic [OCC_W-1:0]         rsp_occupancy;

   dense_set_with_random_pick_unit #(.CAPACITY(CAPACITY)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_value        (req_value),
      .req_random_draw  (req_random_draw),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_picked_value (rsp_picked_value),
      .rsp_occupancy    (rsp_occupancy)
   );

   set_scoreboard sb;
   data_type      value_pool[POOL_SIZE];
   int unsigned   cycles_run   = 0;
   int unsigned   burst_left   = 0;
   bit            sender_gaps  = 1'b1;
   int unsigned   words_random = 0;
   int unsigned   rx_tick      = 0;
   int unsigned   rx_hold      = 0;

   // 8 ns clock
   initial begin
      forever #4 clock = ~clock;
   end

   // Watchdog: give up if the run hangs.
   always @(posedge clock) begin
      cycles_run++;
      if (cycles_run > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver backpressure: the mode rotates with the upper bits of a tick counter through
   // always-ready, coin-flip, long stall windows and rare single stalls.
   always @(posedge clock) begin
      rx_tick++;
      case ((rx_tick >> 10) % 4)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: begin
            if (rx_hold != 0) begin
               rx_hold--;
            end else if (rsp_ready) begin
               rsp_ready <= 1'b0;
               rx_hold = $urandom_range(1, 40);
            end else begin
               rsp_ready <= 1'b1;
               rx_hold = $urandom_range(1, 6);
            end
         end
         default: rsp_ready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // Check every response word on its handshake edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_status, rsp_picked_value, rsp_occupancy);
   end

   // -------------------------------------------------------------------------
   // Driving tasks
   // -------------------------------------------------------------------------

   // Send one request word. Call right after a rising edge; returns right after
   // the edge that accepted the word, with req_valid still high.
   task automatic issue_word(cmd_type cmd, data_type value, data_type draw);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = 0;
         if (sender_gaps)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90)
                                               : $urandom_range(0, 12);
         // drop valid only when a real gap follows
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_cmd         <= cmd;
      req_value       <= value;
      req_random_draw <= draw;
      req_valid       <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(cmd, value, draw);
      burst_left--;
   endtask

   function automatic data_type random_draw_value();
      int unsigned r;
      r = $urandom_range(0, 7);
      if (r < 2) return $urandom_range(0, 200);
      if (r == 2) return '1;
      return $urandom;
   endfunction

   // Mostly values from a reused pool so that hits and misses both occur.
   function automatic data_type random_set_value();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return value_pool[$urandom_range(0, POOL_SIZE-1)];
   endfunction

   function automatic data_type removal_value();
      if (sb.held_count != 0 && $urandom_range(0, 9) < 6)
         return sb.held[$urandom_range(0, sb.held_count-1)];
      return random_set_value();
   endfunction

   // Corner cases: empty set, unused command, extreme values, duplicates,
   // pick draws at both ends, removal of the first and of the last entry.
   task automatic run_directed();
      issue_word(CMD_PICK,   32'd0,        32'hFFFF_FFFF);
      issue_word(CMD_REMOVE, 32'd5,        32'd0);
      issue_word(CMD_NOP,    32'h1234_5678, 32'h9ABC_DEF0);
      issue_word(CMD_INSERT, 32'h8000_0000, 32'd0);
      issue_word(CMD_INSERT, 32'h7FFF_FFFF, 32'd0);
      issue_word(CMD_INSERT, 32'd0,        32'd0);
      issue_word(CMD_INSERT, 32'hFFFF_FFFF, 32'd0);
      issue_word(CMD_INSERT, 32'h7FFF_FFFF, 32'd0);
      issue_word(CMD_PICK,   32'd0,        32'd0);
      issue_word(CMD_PICK,   32'd0,        32'hFFFF_FFFF);
      issue_word(CMD_PICK,   32'hFFFF_FFFF, 32'd3);
      issue_word(CMD_REMOVE, 32'd12345,    32'd0);
      issue_word(CMD_REMOVE, 32'h8000_0000, 32'd0);
      issue_word(CMD_PICK,   32'd0,        32'd1);
      issue_word(CMD_REMOVE, 32'd0,        32'd0);
      issue_word(CMD_REMOVE, 32'hFFFF_FFFF, 32'd0);
      issue_word(CMD_REMOVE, 32'h7FFF_FFFF, 32'd0);
      issue_word(CMD_REMOVE, 32'h7FFF_FFFF, 32'd0);
      issue_word(CMD_PICK,   32'd0,        32'd7);
      issue_word(CMD_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   // Random segments: fill to capacity, grow-biased, shrink-biased and mixed.
   task automatic run_random();
      int unsigned kind;
      int unsigned seg_len;
      int unsigned r;
      int unsigned guard;
      while (words_random < RANDOM_WORDS) begin
         kind = $urandom_range(0, 4);
         sender_gaps = ($urandom_range(0, 3) != 0);
         // refresh part of the pool now and then
         if ($urandom_range(0, 3) == 0)
            for (int i = 0; i < 10; i++)
               value_pool[$urandom_range(4, POOL_SIZE-1)] = $urandom;
         if (kind == 0) begin
            // fill up, then knock on the full set with present and absent values
            guard = 0;
            while (sb.held_count < CAPACITY && guard < 400) begin
               issue_word(CMD_INSERT, random_set_value(), random_draw_value());
               words_random++;
               guard++;
            end
            for (int i = 0; i < 8; i++) begin
               r = $urandom_range(0, 2);
               issue_word(r == 2 ? CMD_PICK : CMD_INSERT,
                          r == 0 ? sb.held[$urandom_range(0, sb.held_count-1)]
                                 : random_set_value(),
                          random_draw_value());
               words_random++;
            end
         end else begin
            seg_len = $urandom_range(20, 80);
            for (int i = 0; i < seg_len; i++) begin
               r = $urandom_range(0, 99);
               if (r < 3)
                  issue_word(CMD_NOP, $urandom, $urandom);
               else if ((kind == 1 && r < 70) || (kind == 2 && r < 18)
                        || (kind >= 3 && r < 40))
                  issue_word(CMD_INSERT, random_set_value(), random_draw_value());
               else if ((kind == 1 && r < 85) || (kind == 2 && r < 85)
                        || (kind >= 3 && r < 70))
                  issue_word(CMD_REMOVE, removal_value(), random_draw_value());
               else
                  issue_word(CMD_PICK, random_set_value(), random_draw_value());
               words_random++;
            end
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      sb = new();
      for (int i = 0; i < POOL_SIZE; i++) value_pool[i] = $urandom;
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      value_pool[2] = 32'd0;
      value_pool[3] = 32'hFFFF_FFFF;

      // hold reset, then release it
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_random();

      // drop valid, drain the owed responses, then watch for strays
      req_valid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
